FILE: hdl/rcc_pkg.sv
// Shared constants, types and codes for the 3x3 RGB convolution block.
// No dependencies; imported by every module of the block but rcc_ram.
package rcc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;
    localparam int KTOP_BITS  = 48;
    localparam int KBOT_BITS  = 24;
    localparam int DIV_BITS   = 8;

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int X_BITS = $clog2(MAX_WIDTH);
    localparam int Y_BITS = $clog2(MAX_HEIGHT);

    localparam int FIFO_DEPTH = 4;
    localparam int RING_BITS  = $clog2(2 * MAX_WIDTH + 4 + 2 * FIFO_DEPTH);
    localparam int RING_DEPTH = 1 << RING_BITS;

    localparam int CH_BITS    = 8;
    localparam int PIX_BITS   = 3 * CH_BITS;
    localparam int COEF_BITS  = 8;
    localparam int TAPS       = 9;
    localparam int KERN_BITS  = TAPS * COEF_BITS;
    localparam int PROD_BITS  = CH_BITS + 1 + COEF_BITS;
    localparam int ACC_BITS   = PROD_BITS + 4;
    localparam int STEP_BITS  = 4;
    localparam int QBIT_BITS  = 3;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KTOP   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KBOT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIV    = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [RING_BITS-1:0] q;
        logic [X_BITS-1:0]    x;
        logic [Y_BITS-1:0]    y;
        logic                 eof;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_PREP,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

FILE: hdl/rcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rcc_ram #(
    parameter int DATA_BITS = 24,
    parameter int DEPTH     = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_BITS-1:0]     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_BITS-1:0]     rdata
);
    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/rcc_fifo.sv
// Short job queue between the front and back ends of the convolution.
// Depends on rcc_pkg for the job type and depth.
module rcc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rcc_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output rcc_pkg::job_t pop_job,
    output logic          empty
);
    import rcc_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    job_t                slot_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_BITS'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = slot_reg[rd_reg];

    always_comb begin
        wr_next  = (push && !full) ? wr_reg + 1'b1 : wr_reg;
        rd_next  = (pop && !empty) ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if ((push && !full) && !(pop && !empty)) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!(push && !full) && (pop && !empty)) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: hdl/rcc_front.sv
// Front end: accepts pixel and flush beats, writes pixels to the ring store
// and queues one job per output. Depends on rcc_pkg.
module rcc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rcc_pkg::PIX_BITS-1:0]    s_tdata,
    input  logic                            s_tuser,
    input  logic                            restart,
    input  logic [rcc_pkg::W_BITS-1:0]      eff_w,
    input  logic [rcc_pkg::H_BITS-1:0]      eff_h,
    output logic                            ram_we,
    output logic [rcc_pkg::RING_BITS-1:0]   ram_waddr,
    output logic [rcc_pkg::PIX_BITS-1:0]    ram_wdata,
    output logic                            push,
    output rcc_pkg::job_t                   push_job,
    input  logic                            fifo_full
);
    import rcc_pkg::*;

    logic [X_BITS-1:0]    col_reg, col_next;
    logic [Y_BITS-1:0]    row_reg, row_next;
    logic [RING_BITS-1:0] p_reg, p_next;
    logic                 done_reg, done_next;
    logic [RING_BITS-1:0] oq_reg, oq_next;
    logic [X_BITS-1:0]    ox_reg, ox_next;
    logic [Y_BITS-1:0]    oy_reg, oy_next;

    logic accept, is_flush, pix_ok, emit, eof;
    logic col_last, row_last, ox_last, oy_last;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign is_flush = (s_tuser == OP_FLUSH);
    assign col_last = (W_BITS'(col_reg) == eff_w - 1'b1);
    assign row_last = (H_BITS'(row_reg) == eff_h - 1'b1);
    assign ox_last  = (W_BITS'(ox_reg) == eff_w - 1'b1);
    assign oy_last  = (H_BITS'(oy_reg) == eff_h - 1'b1);
    assign pix_ok   = accept && !is_flush && !done_reg;
    assign emit     = accept && (is_flush ? done_reg
                      : (!done_reg && (row_reg >= Y_BITS'(2)
                         || (row_reg == Y_BITS'(1) && col_reg != '0))));
    assign eof      = is_flush && ox_last && oy_last;

    assign ram_we    = pix_ok;
    assign ram_waddr = p_reg;
    assign ram_wdata = {s_tdata[CH_BITS-1:0], s_tdata[2*CH_BITS-1:CH_BITS],
                        s_tdata[3*CH_BITS-1:2*CH_BITS]};
    assign push      = emit;
    assign push_job  = '{q: oq_reg, x: ox_reg, y: oy_reg, eof: eof};

    // a new frame starts where the last one ended in the ring, so jobs of the
    // old frame still queued read pixels that are not overwritten
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        p_next    = p_reg;
        done_next = done_reg;
        oq_next   = oq_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        if (restart || (emit && eof)) begin
            col_next  = '0;
            row_next  = '0;
            p_next    = p_reg;
            done_next = 1'b0;
            oq_next   = p_reg;
            ox_next   = '0;
            oy_next   = '0;
        end else begin
            if (pix_ok) begin
                p_next = p_reg + 1'b1;
                if (col_last) begin
                    col_next = '0;
                    if (row_last) begin
                        done_next = 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            if (emit) begin
                oq_next = oq_reg + 1'b1;
                if (ox_last) begin
                    ox_next = '0;
                    oy_next = oy_reg + 1'b1;
                end else begin
                    ox_next = ox_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            p_reg    <= '0;
            done_reg <= 1'b0;
            oq_reg   <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            p_reg    <= p_next;
            done_reg <= done_next;
            oq_reg   <= oq_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
        end
    end
endmodule

FILE: hdl/rcc_back.sv
// Back end: gathers the 3x3 window from the ring store, accumulates the
// kernel products, divides bit-serially and drives the result beat. Uses rcc_pkg.
module rcc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rcc_pkg::W_BITS-1:0]      eff_w,
    input  logic [rcc_pkg::H_BITS-1:0]      eff_h,
    input  logic [rcc_pkg::KERN_BITS-1:0]   kernel,
    input  logic [rcc_pkg::DIV_BITS-1:0]    eff_div,
    input  logic                            fifo_empty,
    output logic                            pop,
    input  rcc_pkg::job_t                   pop_job,
    output logic [rcc_pkg::RING_BITS-1:0]   ram_raddr,
    input  logic [rcc_pkg::PIX_BITS-1:0]    ram_rdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rcc_pkg::PIX_BITS-1:0]    m_tdata,
    output logic                            m_tlast
);
    import rcc_pkg::*;

    back_state_t state_reg, state_next;
    job_t                  job_reg, job_next;
    logic [RING_BITS-1:0]  base_reg, base_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [1:0]            trow_reg, trow_next;
    logic [1:0]            tcol_reg, tcol_next;
    logic [QBIT_BITS-1:0]  qbit_reg, qbit_next;
    logic signed [ACC_BITS-1:0] acc_reg [3];
    logic signed [ACC_BITS-1:0] acc_next [3];
    logic                  neg_reg [3], neg_next [3];
    logic                  sat_reg [3], sat_next [3];
    logic [CH_BITS-1:0]    quo_reg [3], quo_next [3];
    logic                  mvalid_reg, mvalid_next;
    logic [PIX_BITS-1:0]   mdata_reg, mdata_next;
    logic                  mlast_reg, mlast_next;

    logic [RING_BITS-1:0]       row_base;
    logic [X_BITS-1:0]          xx;
    logic [STEP_BITS-1:0]       kidx;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [PROD_BITS-1:0] prod [3];
    logic [ACC_BITS-1:0]        trial;
    logic [ACC_BITS-1:0]        dshift;
    logic                       load_out;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    always_comb begin
        case (trow_reg)
            2'd0:    row_base = (job_reg.y != '0) ? base_reg - RING_BITS'(eff_w) : base_reg;
            2'd2:    row_base = (H_BITS'(job_reg.y) != eff_h - 1'b1)
                                ? base_reg + RING_BITS'(eff_w) : base_reg;
            default: row_base = base_reg;
        endcase
        case (tcol_reg)
            2'd0:    xx = (job_reg.x != '0) ? job_reg.x - 1'b1 : job_reg.x;
            2'd2:    xx = (W_BITS'(job_reg.x) != eff_w - 1'b1) ? job_reg.x + 1'b1 : job_reg.x;
            default: xx = job_reg.x;
        endcase
        ram_raddr = row_base + RING_BITS'(xx);
    end

    assign kidx   = step_reg - 1'b1;
    assign coef   = kernel[kidx*COEF_BITS +: COEF_BITS];
    assign trial  = ACC_BITS'(eff_div) << qbit_reg;
    assign dshift = ACC_BITS'({eff_div, {CH_BITS{1'b0}}});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = $signed({1'b0, ram_rdata[(2-c)*CH_BITS +: CH_BITS]}) * coef;
        end
    end

    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        base_next   = base_reg;
        step_next   = step_reg;
        trow_next   = trow_reg;
        tcol_next   = tcol_reg;
        qbit_next   = qbit_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        quo_next    = quo_reg;
        pop         = 1'b0;
        load_out    = 1'b0;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        case (state_reg)
            B_IDLE: begin
                if (!fifo_empty) begin
                    pop        = 1'b1;
                    job_next   = pop_job;
                    base_next  = pop_job.q - RING_BITS'(pop_job.x);
                    step_next  = '0;
                    trow_next  = '0;
                    tcol_next  = '0;
                    for (int c = 0; c < 3; c++) acc_next[c] = '0;
                    state_next = B_MAC;
                end
            end
            B_MAC: begin
                if (step_reg != '0) begin
                    for (int c = 0; c < 3; c++) acc_next[c] = acc_reg[c] + ACC_BITS'(prod[c]);
                end
                if (tcol_reg == 2'd2) begin
                    tcol_next = '0;
                    trow_next = trow_reg + 1'b1;
                end else begin
                    tcol_next = tcol_reg + 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(TAPS)) begin
                    state_next = B_PREP;
                end
            end
            B_PREP: begin
                for (int c = 0; c < 3; c++) begin
                    neg_next[c] = acc_reg[c][ACC_BITS-1];
                    sat_next[c] = !acc_reg[c][ACC_BITS-1] && ($unsigned(acc_reg[c]) >= dshift);
                    quo_next[c] = '0;
                end
                qbit_next  = '1;
                state_next = B_DIV;
            end
            B_DIV: begin
                for (int c = 0; c < 3; c++) begin
                    if ($unsigned(acc_reg[c]) >= trial) begin
                        acc_next[c]           = acc_reg[c] - $signed(trial);
                        quo_next[c][qbit_reg] = 1'b1;
                    end
                end
                qbit_next = qbit_reg - 1'b1;
                if (qbit_reg == '0) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    load_out = 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        mdata_next[c*CH_BITS +: CH_BITS] = neg_reg[c] ? '0
                                                           : sat_reg[c] ? '1 : quo_reg[c];
                    end
                    mlast_next = job_reg.eof;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
        mvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        base_reg  <= base_next;
        step_reg  <= step_next;
        trow_reg  <= trow_next;
        tcol_reg  <= tcol_next;
        qbit_reg  <= qbit_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        sat_reg   <= sat_next;
        quo_reg   <= quo_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

FILE: hdl/rgb_conv3x3_clamped.sv
// Top level of the 3x3 RGB convolution with replicated borders.
// Depends on rcc_pkg, rcc_ram, rcc_fifo, rcc_front and rcc_back.
//
// Pixels enter in raster order on s_ (tuser = 0 for a pixel, 1 for a flush
// beat); each output lags its pixel by one row plus one pixel, and the last
// row plus one outputs are drawn out by flush beats, the final one with
// m_tlast set. Each output in the back end takes nine window reads through
// the single read port of the ring store, one per cycle, then an eight-step
// bit-serial divide and the output load. Pixels that produce no output are
// taken one per cycle while the four-entry job queue has room. Geometry and
// kernel must be written over cfg_ only while idle; the block does not enforce it.
module rgb_conv3x3_clamped (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rcc_pkg::PIX_BITS-1:0]         s_tdata,   // in_red, in_green, in_blue
    input  logic                                 s_tuser,   // op
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rcc_pkg::PIX_BITS-1:0]         m_tdata,   // out_red, out_green, out_blue
    output logic                                 m_tlast,   // end_of_frame
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rcc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rcc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rcc_pkg::*;

    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [KTOP_BITS-1:0]  ktop_reg;
    logic [KBOT_BITS-1:0]  kbot_reg;
    logic [DIV_BITS-1:0]   div_reg;

    logic [W_BITS-1:0]    eff_w;
    logic [H_BITS-1:0]    eff_h;
    logic [DIV_BITS-1:0]  eff_div;
    logic                 cfg_wr, restart;

    logic                 ram_we;
    logic [RING_BITS-1:0] ram_waddr, ram_raddr;
    logic [PIX_BITS-1:0]  ram_wdata, ram_rdata;
    logic                 push, pop, fifo_full, fifo_empty;
    job_t                 push_job, pop_job;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    assign eff_w = (width_reg == '0) ? W_BITS'(1)
                 : (32'(width_reg) > MAX_WIDTH) ? W_BITS'(MAX_WIDTH) : W_BITS'(width_reg);
    assign eff_h = (height_reg == '0) ? H_BITS'(1)
                 : (32'(height_reg) > MAX_HEIGHT) ? H_BITS'(MAX_HEIGHT) : H_BITS'(height_reg);
    assign eff_div = (div_reg == '0) ? DIV_BITS'(1) : div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W_BITS'(640);
            height_reg <= CFG_H_BITS'(480);
            ktop_reg   <= KTOP_BITS'(48'h0101_0101_0101);
            kbot_reg   <= KBOT_BITS'(24'h01_0101);
            div_reg    <= DIV_BITS'(9);
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[CFG_W_BITS-1:0];
                REG_HEIGHT: height_reg <= cfg_data[CFG_H_BITS-1:0];
                REG_KTOP:   ktop_reg   <= cfg_data[KTOP_BITS-1:0];
                REG_KBOT:   kbot_reg   <= cfg_data[KBOT_BITS-1:0];
                REG_DIV:    div_reg    <= cfg_data[DIV_BITS-1:0];
                default: ;
            endcase
        end
    end

    rcc_ram #(
        .DATA_BITS (PIX_BITS),
        .DEPTH     (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .restart   (restart),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    rcc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (fifo_empty)
    );

    rcc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .kernel     ({kbot_reg, ktop_reg}),
        .eff_div    (eff_div),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .pop_job    (pop_job),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );
endmodule

FILE: hdl/rcc_checker.sv
// Port-level checks for rgb_conv3x3_clamped, bound to the top level.
// Depends on rcc_pkg for port widths.
module rcc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [rcc_pkg::PIX_BITS-1:0]         m_tdata,
    input logic                                 m_tlast,
    input logic                                 cfg_ready
);
    import rcc_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid straight after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready with an empty queue after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration channel not ready");
endmodule

bind rgb_conv3x3_clamped rcc_checker u_rcc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

FILE: tb/sv/tb_rgb_conv3x3_clamped.sv
// Self-checking testbench for rgb_conv3x3_clamped: drives raster frames and flush beats,
// predicts every filtered pixel with a behavioural model and compares it beat by beat.
// Depends on rcc_pkg and the rgb_conv3x3_clamped RTL.
module tb_rgb_conv3x3_clamped;
    import rcc_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int SETTLE       = 150;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
    } pix_res_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [PIX_BITS-1:0]      s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [PIX_BITS-1:0]      m_tdata;
    logic                     m_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // predictor state
    logic [11:0] img_w;
    logic [12:0] img_h;
    logic [47:0] kern_top;
    logic [23:0] kern_bot;
    logic [7:0]  div_val;
    logic [23:0] frame_px[int];
    int          col_cnt, row_cnt, done_cnt;
    bit          frame_in;

    pix_res_t    filtered_q[$];
    int          errors = 0;
    int          s_beats = 0, cfg_beats = 0, out_beats = 0, cycles = 0;
    int          idle_mode = 0;
    int          hold_left = 0;

    always #2 aclk = ~aclk;

    rgb_conv3x3_clamped i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic int eff_w();
        int w;
        w = img_w;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_h();
        int h;
        h = img_h;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic int coef(int i);
        logic [7:0] b;
        b = (i < 6) ? kern_top[8*i +: 8] : kern_bot[8*(i-6) +: 8];
        return int'($signed(b));
    endfunction

    task automatic restart_frame();
        col_cnt = 0;
        row_cnt = 0;
        done_cnt = 0;
        frame_in = 0;
        frame_px.delete();
    endtask

    function automatic logic [7:0] saturate_div(int sum);
        int d, q;
        d = (div_val == 0) ? 1 : div_val;
        q = sum / d;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    task automatic push_filtered(bit eof);
        int w, h, y, x, yy, xx, k, sr, sg, sb;
        logic [23:0] px;
        pix_res_t res;
        w = eff_w();
        h = eff_h();
        y = done_cnt / w;
        x = done_cnt % w;
        sr = 0; sg = 0; sb = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                yy = y + dy;
                xx = x + dx;
                if (yy < 0) yy = 0;
                if (yy > h - 1) yy = h - 1;
                if (xx < 0) xx = 0;
                if (xx > w - 1) xx = w - 1;
                px = frame_px[yy * w + xx];
                k = coef((dy + 1) * 3 + dx + 1);
                sr += k * int'(px[23:16]);
                sg += k * int'(px[15:8]);
                sb += k * int'(px[7:0]);
            end
        end
        res.red = saturate_div(sr);
        res.green = saturate_div(sg);
        res.blue = saturate_div(sb);
        res.eof = eof;
        filtered_q.push_back(res);
        done_cnt++;
    endtask

    task automatic predict_beat(logic op, logic [23:0] data);
        int w, h, p;
        w = eff_w();
        h = eff_h();
        if (op == OP_PIXEL) begin
            if (frame_in) return;
            if (col_cnt >= w || row_cnt >= h) restart_frame();
            p = row_cnt * w + col_cnt;
            frame_px[p] = {data[7:0], data[15:8], data[23:16]};
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) frame_in = 1;
            end
            if (p >= w + 1 && done_cnt + w + 1 <= p) push_filtered(0);
        end else begin
            if (!frame_in || done_cnt >= w * h) return;
            if (done_cnt + 1 == w * h) begin
                push_filtered(1);
                restart_frame();
            end else begin
                push_filtered(0);
            end
        end
    endtask

    task automatic apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] val);
        case (idx)
            REG_WIDTH: begin
                img_w = val[11:0];
                restart_frame();
            end
            REG_HEIGHT: begin
                img_h = val[12:0];
                restart_frame();
            end
            REG_KTOP: kern_top = val;
            REG_KBOT: kern_bot = val[23:0];
            REG_DIV: div_val = val[7:0];
            default: ;
        endcase
    endtask

    // sample all handshakes at the rising edge
    always @(posedge aclk) begin
        pix_res_t want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
                cfg_beats++;
            end
            if (s_tvalid && s_tready) begin
                predict_beat(s_tuser, s_tdata);
                s_beats++;
            end
            if (m_tvalid && m_tready) begin
                out_beats++;
                if (filtered_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, actual %h last %b", $time, m_tdata, m_tlast);
                end else begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== {want.blue, want.green, want.red} || m_tlast !== want.eof) begin
                        errors++;
                        $display("%0t: mismatch, expected %h last %b, actual %h last %b", $time,
                                 {want.blue, want.green, want.red}, want.eof, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // receiver: random stall plus long hold-off counted here
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else if (idle_mode == 2 || idle_mode == 3) begin
            m_tready = ($urandom_range(99) >= ((idle_mode == 2) ? 84 : 7));
        end else begin
            m_tready = 1'b1;
        end
    end

    function automatic bit sender_idles();
        if (idle_mode == 1) return $urandom_range(99) < 84;
        if (idle_mode == 3) return $urandom_range(99) < 7;
        return 0;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(logic op, logic [23:0] data);
        int n;
        while (sender_idles()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser = op;
        s_tdata = data;
        s_tvalid = 1'b1;
        n = s_beats;
        wait (s_beats != n);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [23:0] rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    task automatic drain();
        s_tvalid = 1'b0;
        wait (filtered_q.size() == 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] val);
        int n;
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        n = cfg_beats;
        wait (cfg_beats != n);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(int w, int h, logic [47:0] kt, logic [23:0] kb, logic [7:0] d);
        drain();
        write_reg(REG_WIDTH, 48'(w));
        write_reg(REG_HEIGHT, 48'(h));
        write_reg(REG_KTOP, kt);
        write_reg(REG_KBOT, 48'(kb));
        write_reg(REG_DIV, 48'(d));
    endtask

    // one frame of pixels then flush beats until it closes; noise adds stray beats
    task automatic run_frame(bit noise);
        int total;
        total = eff_w() * eff_h();
        for (int p = 0; p < total; p++) begin
            if (noise && $urandom_range(19) == 0) send_beat(OP_FLUSH, rand_pixel());
            send_beat(OP_PIXEL, rand_pixel());
        end
        while (frame_in) begin
            if (noise && $urandom_range(9) == 0) send_beat(OP_PIXEL, rand_pixel());
            send_beat(OP_FLUSH, 24'($urandom));
        end
        if (noise && $urandom_range(3) == 0) send_beat(OP_FLUSH, 24'($urandom));
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic test_directed();
        idle_mode = 0;
        setup(3, 2, 48'h000001_000000, 24'h000000, 8'd1);
        send_beat(OP_FLUSH, 24'h000000);
        send_beat(OP_PIXEL, 24'h000000);
        send_beat(OP_PIXEL, 24'hffffff);
        send_beat(OP_PIXEL, 24'h0000ff);
        send_beat(OP_PIXEL, 24'h00ff00);
        send_beat(OP_PIXEL, 24'hff0000);
        send_beat(OP_PIXEL, 24'h123456);
        send_beat(OP_PIXEL, 24'habcdef);
        while (frame_in) send_beat(OP_FLUSH, 24'h0);
        send_beat(OP_FLUSH, 24'h0);
        setup(2, 2, 48'h7f7f7f_7f7f7f, 24'h7f7f7f, 8'd0);
        run_frame(0);
        setup(2, 3, 48'h808080_808080, 24'h808080, 8'd255);
        run_frame(0);
        setup(0, 0, 48'hffffff_ffffff, 24'hffffff, 8'd1);
        run_frame(0);
        drain();
        for (int i = 5; i < 8; i++) write_reg(CFG_IDX_BITS'(i), rand48());
        run_frame(0);
    endtask

    // oversize geometry: partial frames, then the next geometry write restarts
    task automatic test_geometry_extremes();
        idle_mode = 0;
        setup(4095, 0, 48'h010101_010101, 24'h010101, 8'd9);
        for (int p = 0; p < 150; p++) send_beat(OP_PIXEL, rand_pixel());
        send_beat(OP_FLUSH, 24'h0);
        setup(1, 8191, 48'h00ff00_ff04ff, 24'h00ff00, 8'd1);
        for (int p = 0; p < 150; p++) send_beat(OP_PIXEL, rand_pixel());
        send_beat(OP_FLUSH, 24'h0);
    endtask

    task automatic test_random(int mode, int items);
        int start;
        idle_mode = mode;
        start = s_beats;
        while (s_beats - start < items) begin
            setup($urandom_range(1, 9), $urandom_range(1, 7), rand48(),
                  24'($urandom_range(24'hffffff)), 8'($urandom_range(255)));
            run_frame($urandom_range(3) == 0);
        end
    endtask

    task automatic test_backpressure();
        idle_mode = 0;
        setup(6, 5, rand48(), 24'($urandom), 8'($urandom_range(1, 255)));
        @(negedge aclk);
        hold_left = 400;
        run_frame(0);
    endtask

    initial begin
        img_w = 640;
        img_h = 480;
        kern_top = 48'd1103823438081;
        kern_bot = 24'd65793;
        div_val = 8'd9;
        restart_frame();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_geometry_extremes();
        test_random(0, 220);
        test_random(1, 220);
        test_random(2, 220);
        test_random(3, 220);
        test_backpressure();
        drain();
        $display("Covered %0d input beats, %0d output beats and %0d register writes",
                 s_beats, out_beats, cfg_beats);
        $display("across edge geometries, kernels, divisors and four idle patterns");
        if (errors == 0 && filtered_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
